>>> design/rpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB pixel blend package
// Shared types and codes for the pixel blend pipeline: blend modes, beat
// payloads and the per-channel record carried between the two stages.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int ChanW = 8;
  localparam int NumW  = 17;  // (k*m*n + 255) / 2 for k up to 4 and 8-bit m, n

  typedef enum logic [2:0] {
    MODE_MULTIPLY = 3'd0,
    MODE_SCREEN   = 3'd1,
    MODE_SUBTRACT = 3'd2,
    MODE_ADD      = 3'd3,
    MODE_OVERLAY  = 3'd4
  } blend_mode_t;

  // How the back stage turns the front stage record into a channel value.
  typedef enum logic [1:0] {
    FIN_DIRECT  = 2'd0,
    FIN_DIV     = 2'd1,
    FIN_DIV_INV = 2'd2
  } fin_kind_t;

  typedef struct packed {
    logic [ChanW-1:0] base_blue;
    logic [ChanW-1:0] base_green;
    logic [ChanW-1:0] base_red;
    logic [ChanW-1:0] top_blue;
    logic [ChanW-1:0] top_green;
    logic [ChanW-1:0] top_red;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_red;
  } pix_out_t;

  typedef struct packed {
    fin_kind_t        kind;
    logic [NumW-1:0]  num;     // value to be divided by 255 (floor)
    logic [ChanW-1:0] direct;  // finished value for add, subtract, unused codes
  } chan_mid_t;

endpackage

>>> design/rpb_mul_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blend front stage, one channel
// Picks the multiplier operands for the mode, forms the rounding numerator
// and computes the saturating add and clamped subtract results.
// ----------------------------------------------------------------------------
module rpb_mul_stage
  import rpb_pkg::*;
(
  input  logic [2:0]       mode,
  input  logic [ChanW-1:0] base_val,
  input  logic [ChanW-1:0] top_val,
  output chan_mid_t        mid
);

  logic [ChanW-1:0]   inv_base;
  logic [ChanW-1:0]   inv_top;
  logic [ChanW-1:0]   op_m;
  logic [ChanW-1:0]   op_n;
  logic               dbl;
  logic [2*ChanW-1:0] prod;
  logic [NumW:0]      prod_sc;
  logic [NumW:0]      rnd;
  logic [ChanW:0]     sum;
  logic               top_hi;
  fin_kind_t          fin_kind;
  logic [ChanW-1:0]   direct_val;

  assign inv_base = 8'd255 - base_val;
  assign inv_top  = 8'd255 - top_val;
  assign top_hi   = top_val[ChanW-1];  // top value of 128 or more

  always_comb begin
    op_m       = base_val;
    op_n       = top_val;
    dbl        = 1'b0;
    fin_kind   = FIN_DIRECT;
    direct_val = '0;
    case (mode)
      MODE_MULTIPLY: begin
        fin_kind = FIN_DIV;
      end
      MODE_SCREEN: begin
        op_m     = inv_base;
        op_n     = inv_top;
        fin_kind = FIN_DIV_INV;
      end
      MODE_SUBTRACT: begin
        direct_val = (base_val > top_val) ? (base_val - top_val) : '0;
      end
      MODE_ADD: begin
        direct_val = sum[ChanW] ? 8'd255 : sum[ChanW-1:0];
      end
      MODE_OVERLAY: begin
        dbl = 1'b1;
        if (top_hi) begin
          op_m     = inv_base;
          op_n     = inv_top;
          fin_kind = FIN_DIV_INV;
        end else begin
          fin_kind = FIN_DIV;
        end
      end
      default: begin
        direct_val = '0;
      end
    endcase
  end

  assign sum  = {1'b0, base_val} + {1'b0, top_val};
  assign prod = op_m * op_n;

  // Twice (or four times) the product plus 255, then halved: dividing the
  // result by 255 gives the product (twice it, for overlay) over 255 rounded half up.
  assign prod_sc = dbl ? {prod, 2'b00} : {1'b0, prod, 1'b0};
  assign rnd     = prod_sc + (NumW+1)'(255);
  assign mid     = '{kind: fin_kind, num: rnd[NumW:1], direct: direct_val};

endmodule

>>> design/rpb_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blend back stage, one channel
// Divides the rounding numerator by 255 with a reciprocal estimate and a
// single correction, then applies the inversion for screen-like modes.
// ----------------------------------------------------------------------------
module rpb_div_stage
  import rpb_pkg::*;
(
  input  chan_mid_t        mid,
  output logic [ChanW-1:0] res
);

  logic [NumW+7:0]  est_full;
  logic [8:0]       q_est;
  logic [NumW-1:0]  back;
  logic [NumW-1:0]  rem;
  logic [8:0]       q_fix;
  logic [ChanW-1:0] quo;

  // num * 257 / 65536 undershoots num / 255 by less than one, so the
  // estimate is the true quotient or one below it.
  assign est_full = {mid.num, 8'b0} + {8'b0, mid.num};
  assign q_est    = est_full[NumW+7:16];
  assign back     = {q_est, 8'b0} - NumW'(q_est);
  assign rem      = mid.num - back;
  assign q_fix    = (rem >= NumW'(255)) ? (q_est + 9'd1) : q_est;
  assign quo      = q_fix[ChanW-1:0];

  always_comb begin
    case (mid.kind)
      FIN_DIV:     res = quo;
      FIN_DIV_INV: res = 8'd255 - quo;
      FIN_DIRECT:  res = mid.direct;
      default:     res = '0;
    endcase
  end

endmodule

>>> design/rgb_pixel_blend_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB pixel blend unit
// Blends a base and a top RGB888 pixel channel by channel in one of five
// layer blend modes chosen by a configuration register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on in_pixel carries one base pixel and one top pixel;
//   each output beat on out_pixel carries the blended pixel. Both channels
//   use valid/ready. cfg_wr_en writes cfg_wr_data into the blend mode
//   register on the same edge; write it only while no beat is in flight.
//   The datapath is three register stages: input register, product register
//   (8x8 multiply per channel) and output register (divide by 255 and
//   finish). An accepted beat passes through the input, product and
//   output registers in turn to out_valid; with out_ready held high one beat
//   is taken and one delivered every cycle. When the receiver stalls, each
//   stage holds until the one after it frees up, so up to three beats are
//   buffered before in_ready drops; in_ready is high whenever out_ready is
//   high. Reset empties all stages and sets the mode to multiply.
// ----------------------------------------------------------------------------
module rgb_pixel_blend_unit_core
  import rpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_in_t  in_pixel,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_out_t out_pixel
);

  logic [2:0] mode_r;
  logic       v0_r, v1_r, v2_r;
  pix_in_t    pix_r;
  chan_mid_t  mid_b_r, mid_g_r, mid_r_r;
  pix_out_t   res_r;

  chan_mid_t  mid_b_nxt, mid_g_nxt, mid_r_nxt;
  pix_out_t   res_nxt;
  logic       ld0, ld1, ld2;

  // Each stage loads when it is empty or its content moves on this cycle.
  assign ld2      = !v2_r || out_ready;
  assign ld1      = !v1_r || ld2;
  assign ld0      = !v0_r || ld1;
  assign in_ready = ld0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MULTIPLY;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (ld0) begin
        v0_r <= in_valid;
      end
      if (ld1) begin
        v1_r <= v0_r;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      pix_r <= in_pixel;
    end
    if (ld1) begin
      mid_b_r <= mid_b_nxt;
      mid_g_r <= mid_g_nxt;
      mid_r_r <= mid_r_nxt;
    end
    if (ld2) begin
      res_r <= res_nxt;
    end
  end

  rpb_mul_stage u_mul_b (
    .mode     (mode_r),
    .base_val (pix_r.base_blue),
    .top_val  (pix_r.top_blue),
    .mid      (mid_b_nxt)
  );

  rpb_mul_stage u_mul_g (
    .mode     (mode_r),
    .base_val (pix_r.base_green),
    .top_val  (pix_r.top_green),
    .mid      (mid_g_nxt)
  );

  rpb_mul_stage u_mul_r (
    .mode     (mode_r),
    .base_val (pix_r.base_red),
    .top_val  (pix_r.top_red),
    .mid      (mid_r_nxt)
  );

  rpb_div_stage u_div_b (
    .mid (mid_b_r),
    .res (res_nxt.out_blue)
  );

  rpb_div_stage u_div_g (
    .mid (mid_g_r),
    .res (res_nxt.out_green)
  );

  rpb_div_stage u_div_r (
    .mid (mid_r_r),
    .res (res_nxt.out_red)
  );

  assign out_valid = v2_r;
  assign out_pixel = res_r;

endmodule

>>> design/rpb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB pixel blend port checker
// Watches the top level ports for handshake and flow-control slips; bound
// to the top level below.
// ----------------------------------------------------------------------------
module rpb_checker
  import rpb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input pix_out_t out_pixel
);

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // A receiver that takes beats never causes back-pressure at the input.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the beat was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("out_pixel changed while stalled");

endmodule

bind rgb_pixel_blend_unit_core rpb_checker u_rpb_checker (.*);
